/* rtl/core/slfp_pkg.sv */
// ----------------------------------------------------------------------------
// slfp_pkg: shared types and constants of the sync/length frame parser
// Holds the sync bytes, the phase encoding and the result record that
// travels from the parser to the output register.
// ----------------------------------------------------------------------------
package slfp_pkg;

   localparam logic [7:0]  SYNC_FIRST        = 8'h0A;
   localparam logic [7:0]  SYNC_SECOND       = 8'hEE;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd4096;
   localparam logic [1:0]  HDR_LAST_BYTE     = 2'd3;

   // one-hot parse phases
   typedef enum logic [4:0] {
      PH_HUNT0   = 5'b00001,
      PH_HUNT1   = 5'b00010,
      PH_CMD     = 5'b00100,
      PH_LEN     = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [31:0] frame_cmd;
      logic [7:0]  payload_byte;
      logic        byte_valid;
      logic        frame_last;
      logic        length_error;
   } result_type;

endpackage

/* rtl/core/slfp_parser.sv */
// ----------------------------------------------------------------------------
// slfp_parser: framing state machine
// Hunts for the sync pair, collects the command and length words, counts
// payload bytes and forms one result record for each beat that makes one.
// ----------------------------------------------------------------------------
module slfp_parser
   import slfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        beat,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] max_len,
   output logic        res_valid,
   output result_type  res
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  count_ff, count_in;
   logic [31:0] cmd_ff, cmd_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] len_full;

   assign len_full = {len_ff[23:0], rx_byte};

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      cmd_in    = cmd_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      res_valid = 1'b0;
      res       = '{frame_cmd: cmd_ff, payload_byte: 8'd0, byte_valid: 1'b0,
                    frame_last: 1'b0, length_error: 1'b0};
      if (beat) begin
         unique case (phase_ff)
            PH_HUNT0: begin
               if (rx_byte == SYNC_FIRST) phase_in = PH_HUNT1;
            end
            PH_HUNT1: begin
               if (rx_byte == SYNC_SECOND) begin
                  phase_in = PH_CMD;
                  count_in = 2'd0;
                  cmd_in   = 32'd0;
               end else if (rx_byte != SYNC_FIRST) begin
                  phase_in = PH_HUNT0;
               end
            end
            PH_CMD: begin
               cmd_in = {cmd_ff[23:0], rx_byte};
               if (count_ff == HDR_LAST_BYTE) begin
                  count_in = 2'd0;
                  len_in   = 32'd0;
                  phase_in = PH_LEN;
               end else begin
                  count_in = count_ff + 2'd1;
               end
            end
            PH_LEN: begin
               len_in = len_full;
               if (count_ff != HDR_LAST_BYTE) begin
                  count_in = count_ff + 2'd1;
               end else begin
                  count_in = 2'd0;
                  if (len_full > {16'd0, max_len}) begin
                     phase_in         = PH_HUNT0;
                     res_valid        = 1'b1;
                     res.frame_last   = 1'b1;
                     res.length_error = 1'b1;
                  end else if (len_full == 32'd0) begin
                     phase_in       = PH_HUNT0;
                     res_valid      = 1'b1;
                     res.frame_last = 1'b1;
                  end else begin
                     rem_in   = len_full[15:0];
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               rem_in           = rem_ff - 16'd1;
               res_valid        = 1'b1;
               res.payload_byte = rx_byte;
               res.byte_valid   = 1'b1;
               res.frame_last   = (rem_ff == 16'd1);
               if (rem_ff == 16'd1) phase_in = PH_HUNT0;
            end
            default: begin
               phase_in = PH_HUNT0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT0;
         count_ff <= 2'd0;
         cmd_ff   <= 32'd0;
         len_ff   <= 32'd0;
         rem_ff   <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

/* rtl/core/slfp_out_reg.sv */
// ----------------------------------------------------------------------------
// slfp_out_reg: result register
// Holds one result beat toward the receiver; takes a new one in the cycle
// the held beat leaves.
// ----------------------------------------------------------------------------
module slfp_out_reg
   import slfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_data,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff;
   result_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

/* rtl/core/sync_length_frame_parser.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_parser: byte-stream deframer
// Finds sync pair 0x0A 0xEE, reads a command and a length word, and forwards
// the payload bytes tagged with the command.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one received byte per beat (req_rx_byte).
//   rsp_*  : at most one result beat per request beat: a payload byte with
//            its frame command, an empty-frame marker, or a length error.
//            rsp_frame_last marks the final beat of a frame.
//   csr_*  : write of max_payload_len; always ready, write only while idle.
// Timing: a result beat is registered and appears in the cycle after the
//   request beat that caused it. Throughput: one byte per clock when not
//   stalled, set by the single parse stage and one-entry result register.
// Header bytes give no beat unless they end an empty or oversized frame.
// Reset: hunting for the first sync byte, max_payload_len = 4096, result
//   register empty.
// Stall: while a result is held and rsp_ready is low, req_ready drops and
//   the parser state holds; nothing is lost.
// ----------------------------------------------------------------------------
module sync_length_frame_parser
   import slfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_frame_cmd,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_frame_last,
   output logic        rsp_length_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_payload_len
);

   logic [15:0] max_len_ff;
   logic        beat;
   logic        res_valid;
   result_type  res;
   result_type  out_data;
   logic        stage_ready;

   // config register: accepted every cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_valid) begin
         max_len_ff <= csr_max_payload_len;
      end
   end

   // advance the parser only when the result register can take a beat
   assign req_ready = stage_ready;
   assign beat      = req_valid && stage_ready;

   slfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .rx_byte   (req_rx_byte),
      .max_len   (max_len_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   slfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (stage_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_frame_cmd    = out_data.frame_cmd;
   assign rsp_payload_byte = out_data.payload_byte;
   assign rsp_byte_valid   = out_data.byte_valid;
   assign rsp_frame_last   = out_data.frame_last;
   assign rsp_length_error = out_data.length_error;

endmodule

/* tb/sv/slfp_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfp_tb_pkg: deframer tracker for the sync/length frame parser bench
// Mirrors the parser state for each byte the block accepts, keeps the
// result beats still owed, and checks the beats that come back in order.
// ----------------------------------------------------------------------------
package slfp_tb_pkg;

   import slfp_pkg::*;

   class deframe_tracker;

      phase_type   phase;
      logic [1:0]  hdr_count;
      logic [31:0] cmd_word;
      logic [31:0] len_word;
      logic [15:0] bytes_left;
      logic [15:0] max_len;
      result_type  owed_beats[$];
      int          beats_seen;
      int          errors;

      function new();
         phase      = PH_HUNT0;
         hdr_count  = '0;
         cmd_word   = '0;
         len_word   = '0;
         bytes_left = '0;
         max_len    = MAX_PAYLOAD_RESET;
         beats_seen = 0;
         errors     = 0;
      endfunction

      function void set_max_len(logic [15:0] value);
         max_len = value;
      endfunction

      function int owed();
         return owed_beats.size();
      endfunction

      function void owe_beat(logic [7:0] data, logic valid, logic last, logic err);
         result_type beat;
         beat.frame_cmd    = cmd_word;
         beat.payload_byte = data;
         beat.byte_valid   = valid;
         beat.frame_last   = last;
         beat.length_error = err;
         owed_beats.insert(owed_beats.size(), beat);
      endfunction

      // advance the parser image by one accepted byte
      function void note_byte(logic [7:0] rx);
         case (phase)
            PH_HUNT0: begin
               if (rx == SYNC_FIRST) phase = PH_HUNT1;
            end
            PH_HUNT1: begin
               if (rx == SYNC_SECOND) begin
                  phase     = PH_CMD;
                  hdr_count = '0;
                  cmd_word  = '0;
               end else if (rx != SYNC_FIRST) begin
                  phase = PH_HUNT0;
               end
            end
            PH_CMD: begin
               cmd_word = {cmd_word[23:0], rx};
               if (hdr_count == HDR_LAST_BYTE) begin
                  hdr_count = '0;
                  len_word  = '0;
                  phase     = PH_LEN;
               end else begin
                  hdr_count = hdr_count + 2'd1;
               end
            end
            PH_LEN: begin
               len_word = {len_word[23:0], rx};
               if (hdr_count != HDR_LAST_BYTE) begin
                  hdr_count = hdr_count + 2'd1;
               end else begin
                  hdr_count = '0;
                  if (len_word > {16'd0, max_len}) begin
                     phase = PH_HUNT0;
                     owe_beat(8'h00, 1'b0, 1'b1, 1'b1);
                  end else if (len_word == '0) begin
                     phase = PH_HUNT0;
                     owe_beat(8'h00, 1'b0, 1'b1, 1'b0);
                  end else begin
                     bytes_left = len_word[15:0];
                     phase      = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               bytes_left = bytes_left - 16'd1;
               if (bytes_left == '0) begin
                  phase = PH_HUNT0;
                  owe_beat(rx, 1'b1, 1'b1, 1'b0);
               end else begin
                  owe_beat(rx, 1'b1, 1'b0, 1'b0);
               end
            end
            default: phase = PH_HUNT0;
         endcase
      endfunction

      task report(string msg);
         if (errors < 50) $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("beat %0d %s got %h want %h", beats_seen, name, got, want));
      endtask

      task check_result(result_type got);
         result_type want;
         if (owed_beats.size() == 0) begin
            report($sformatf("beat %0d arrived with nothing owed", beats_seen));
         end else begin
            want = owed_beats.pop_front();
            check_field("frame_cmd", got.frame_cmd, want.frame_cmd);
            check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
            check_field("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
            check_field("frame_last", 32'(got.frame_last), 32'(want.frame_last));
            check_field("length_error", 32'(got.length_error), 32'(want.length_error));
         end
         beats_seen++;
      endtask

      task close_out(output int total_errors);
         if (owed_beats.size() != 0)
            report($sformatf("%0d result beats never arrived", owed_beats.size()));
         total_errors = errors;
      endtask

   endclass

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sync/length frame parser bench
// Feeds the deframer a byte stream of well-formed frames with random content,
// empty and oversized frames, stray noise and broken sync pairs, under
// several max_payload_len settings. Both channels idle at random and the
// result side holds off once for a long stretch. Every result beat is
// checked field by field against the tracker in slfp_tb_pkg.
// ----------------------------------------------------------------------------
module testbench;

   import slfp_pkg::*;
   import slfp_tb_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_frame_cmd;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_byte_valid;
   logic        rsp_frame_last;
   logic        rsp_length_error;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_max_payload_len;

   deframe_tracker tracker = new();

   // idle chance in percent, shared by sender and receiver; 0 means no gaps
   int          idle_pct   = 0;
   // cycles the receiver must hold off, handed over by the stimulus
   int          long_hold  = 0;
   int          frame_bytes = 0;
   logic [15:0] cur_max_len = MAX_PAYLOAD_RESET;
   logic [7:0]  last_byte  = 8'h00;

   // a short hunt, a resync through 0x0A 0x0A 0xEE with extreme command bytes
   // and sync bytes inside the payload, an empty frame, an all-ones length
   logic [7:0] directed_bytes[$] = '{
      8'h0A, 8'h55,
      8'h0A, 8'h0A, 8'hEE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02,
      8'h0A, 8'hEE,
      8'h0A, 8'hEE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h0A, 8'hEE, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF, 8'hFF, 8'hFF, 8'hFF
   };

   logic [15:0] phase_max[7] = '{16'd4096, 16'd0, 16'hFFFF, 16'd1, 16'd16, 16'd0, 16'd4096};
   int          phase_idle[7] = '{0, 30, 0, 60, 15, 40, 25};

   sync_length_frame_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_cmd       (rsp_frame_cmd),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_frame_last      (rsp_frame_last),
      .rsp_length_error    (rsp_length_error),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_payload_len (csr_max_payload_len)
   );

   always #5 clock = ~clock;

   // Gap length: zero unless the idle chance hits; then mostly short, a few long.
   function automatic int pick_gap();
      if ($urandom_range(99) >= idle_pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 8);
      return $urandom_range(3, 1);
   endfunction

   function automatic logic [31:0] pick_cmd();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   // Declared length: mostly small legal sizes, plus empty, exactly max,
   // one past max and huge values that use the upper length bits.
   function automatic logic [31:0] pick_length();
      int          r;
      logic [31:0] lim;
      r   = $urandom_range(99);
      lim = {16'd0, cur_max_len};
      if (r < 10) return 32'd0;
      if (r >= 65 && r < 78) return lim + 32'd1;
      if (r >= 78 && r < 90) return $urandom() | 32'h0001_0000;
      if (lim == 0) return 32'd1;
      if (r < 55) return $urandom_range((lim < 12) ? lim : 12, 1);
      if (r < 65) return (lim <= 64) ? lim : $urandom_range(64, 13);
      return $urandom_range((lim < 40) ? lim : 40, 1);
   endfunction

   // Payload bytes: random, with sync bytes mixed in now and then.
   function automatic logic [7:0] pick_payload();
      int r;
      r = $urandom_range(19);
      if (r == 0) return SYNC_FIRST;
      if (r == 1) return SYNC_SECOND;
      return $urandom_range(255);
   endfunction

   // Offer one beat and hold it until accepted. Called at a rising edge;
   // returns at the edge of acceptance with req_valid still high.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_byte(value);
      last_byte = value;
   endtask

   // Send sync, command and length, then the payload the block will take.
   task automatic send_frame(input logic [31:0] cmd, input logic [31:0] len);
      int count;
      count = (len != 0 && len <= {16'd0, cur_max_len}) ? int'(len) : 0;
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      for (int i = 3; i >= 0; i--) send_byte(cmd[8*i +: 8]);
      for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
      repeat (count) send_byte(pick_payload());
      frame_bytes += 10 + count;
   endtask

   // Stray bytes; never form a sync pair by accident.
   task automatic send_noise(input int count);
      logic [7:0] value;
      repeat (count) begin
         value = $urandom_range(255);
         if (last_byte == SYNC_FIRST && value == SYNC_SECOND) value = 8'h00;
         send_byte(value);
      end
   endtask

   // Drop valid and wait until every owed beat is back, then let the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.owed() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [15:0] value);
      csr_valid           <= 1'b1;
      csr_max_payload_len <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tracker.set_max_len(value);
      cur_max_len = value;
   endtask

   // Result side: check accepted beats and drive rsp_ready with random stalls.
   // A long hold from the stimulus overrides the random pattern.
   initial begin : result_side
      int stall_left;
      result_type got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.frame_cmd    = rsp_frame_cmd;
            got.payload_byte = rsp_payload_byte;
            got.byte_valid   = rsp_byte_valid;
            got.frame_last   = rsp_frame_last;
            got.length_error = rsp_length_error;
            tracker.check_result(got);
         end
         if (long_hold > 0) begin
            stall_left = long_hold;
            long_hold  = 0;
         end
         if (stall_left == 0) stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int r;
      int phase_stop;
      int total_errors;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_rx_byte         = 8'h00;
      rsp_ready           = 1'b0;
      csr_valid           = 1'b0;
      csr_max_payload_len = 16'h0000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed stream under the reset maximum
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      for (int p = 0; p < 7; p++) begin
         drain();
         idle_pct = phase_idle[p];
         if (p > 0) write_max_len((p == 5) ? 16'($urandom_range(300, 2)) : phase_max[p]);
         if (p == 0) begin
            // hold off the result side while a long frame keeps coming
            long_hold = 300;
            send_frame(pick_cmd(), 32'd40);
         end
         phase_stop = frame_bytes + 215;
         while (frame_bytes < phase_stop) begin
            r = $urandom_range(99);
            if (r < 80) begin
               if ($urandom_range(3) == 0) send_noise($urandom_range(2, 1));
               if ($urandom_range(9) == 0) send_byte(SYNC_FIRST);
               send_frame(pick_cmd(), pick_length());
            end else if (r < 90) begin
               send_noise($urandom_range(8, 1));
            end else begin
               // first sync byte followed by a wrong second one
               send_byte(SYNC_FIRST);
               send_noise(1);
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      tracker.close_out(total_errors);
      if (total_errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Watchdog: end a hung run.
   initial begin : watchdog
      #20_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
